FILE: rtl/interval_arithmetic_unit_core_defines.svh
// Assertion macros for the interval ALU core.
// Included by rtl/interval_arithmetic_unit_core.sv; relies on clk and rst in scope.
`ifndef INTERVAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define INTERVAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define IAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define IAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/iau_pkg.sv
// Shared widths, opcodes and sequencer states of the interval ALU.
// No dependencies.
package iau_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int EXP_W    = 7;
  localparam int FUNC_W   = 4;
  localparam int WIDE_W   = 50;              // holds quotients up to 2^48
  localparam int MUL_W    = 34;              // shared multiplier operand width
  localparam int PROD_W   = 64;
  localparam int DVD_W    = WORD_W + FRAC_W; // dividend / quotient bits
  localparam int SQ_W     = WORD_W + FRAC_W;
  localparam int SQ_STEPS = SQ_W / 2;
  localparam int PW_W     = WORD_W + 1;      // power magnitude, capped at 2^31+1
  localparam int CNT_W    = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_MAKE, FN_LO, FN_HI, FN_WIDTH, FN_MID, FN_ADD, FN_SUB, FN_MUL,
    FN_DIV, FN_CONTAINS, FN_OVERLAPS, FN_INTERSECT, FN_HULL, FN_POW,
    FN_SQRT, FN_ABS
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_DIV_INIT, ST_DIV_STEP, ST_DIV_FIX, ST_SQ_INIT,
    ST_SQ_STEP, ST_SQ_FIX, ST_POW_INIT, ST_POW_MUL, ST_POW_ACC, ST_POW_FIX,
    ST_FINISH
  } state_t;

endpackage

FILE: rtl/interval_arithmetic_unit_core.sv
// Interval ALU core: sequencer around one shared multiplier, a radix-2
// divider step and a square-root step. Uses iau_pkg and the defines header.
//
//  channel | handshake        | fields
//  --------+------------------+----------------------------------------------
//  input   | start, busy      | func, a_low, a_high, b_low, b_high,
//          |                  | point_value, exponent
//  result  | done (strobe)    | res_low, res_high, truth, is_null, saturated
//
// div computes four 48-step quotients on the shared divider step, sqrt two
// 24-step roots, and pow with n >= 2 does one multiply per factor.
// busy is high from accept until the done cycle; results hold until the next done.
// rst is synchronous and returns the sequencer to idle; the receiver cannot stall.
`include "interval_arithmetic_unit_core_defines.svh"

module interval_arithmetic_unit_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done,
  input  logic        [iau_pkg::FUNC_W-1:0]    func,
  input  logic signed [iau_pkg::WORD_W-1:0]    a_low,
  input  logic signed [iau_pkg::WORD_W-1:0]    a_high,
  input  logic signed [iau_pkg::WORD_W-1:0]    b_low,
  input  logic signed [iau_pkg::WORD_W-1:0]    b_high,
  input  logic signed [iau_pkg::WORD_W-1:0]    point_value,
  input  logic signed [iau_pkg::EXP_W-1:0]     exponent,
  output logic signed [iau_pkg::WORD_W-1:0]    res_low,
  output logic signed [iau_pkg::WORD_W-1:0]    res_high,
  output logic                                 truth,
  output logic                                 is_null,
  output logic                                 saturated
);
  import iau_pkg::*;

  localparam logic signed [WIDE_W-1:0] WMAX =
    {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WMIN = ~WMAX;
  localparam logic signed [WIDE_W-1:0] ONE_W = WIDE_W'(1) <<< FRAC_W;
  localparam logic [PROD_W-1:0] RND = PROD_W'((64'd1 << FRAC_W) - 64'd1);
  localparam logic [PW_W-1:0] PW_ONE = PW_W'(1) << FRAC_W;
  localparam logic [PW_W-1:0] PW_CAP = (PW_W'(1) << (WORD_W-1)) + PW_W'(1);

  state_t state, state_next, start_path;

  logic signed [WORD_W-1:0] al, ah, bl, bh;
  logic [CNT_W-1:0]         n_r, cnt;
  logic [1:0]               idx;
  logic                     even_straddle;
  logic signed [WIDE_W-1:0] acc_lo, acc_hi;
  logic                     truth_r, null_r;

  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;

  logic [WORD_W-1:0]        rem, dsr;
  logic [DVD_W-1:0]         dvd;
  logic                     dv_neg;
  logic [SQ_W-1:0]          sq_x, sq_r, sq_bit;
  logic [PW_W-1:0]          pw_r;
  logic [WORD_W-1:0]        pw_m;
  logic                     pw_up, pw_neg;

  // start decode
  logic signed [WIDE_W-1:0] wal, wah, wbl, wbh, wpt, s_lo, s_hi, s_t;
  logic                     s_truth, s_null;

  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

  function automatic logic signed [WIDE_W-1:0] mn(input logic signed [WIDE_W-1:0] x,
                                                  input logic signed [WIDE_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic signed [WIDE_W-1:0] mx(input logic signed [WIDE_W-1:0] x,
                                                  input logic signed [WIDE_W-1:0] y);
    return (x > y) ? x : y;
  endfunction

  always_comb begin
    wal = WIDE_W'(a_low);
    wah = WIDE_W'(a_high);
    wbl = WIDE_W'(b_low);
    wbh = WIDE_W'(b_high);
    wpt = WIDE_W'(point_value);
    s_lo = '0;
    s_hi = '0;
    s_t = '0;
    s_truth = 1'b0;
    s_null = 1'b0;
    start_path = ST_FINISH;
    case (func_t'(func))
      FN_MAKE: begin
        s_lo = mn(wal, wah);
        s_hi = mx(wal, wah);
      end
      FN_LO: begin
        s_lo = wal;
        s_hi = wal;
      end
      FN_HI: begin
        s_lo = wah;
        s_hi = wah;
      end
      FN_WIDTH: begin
        s_lo = wah - wal;
        s_hi = wah - wal;
      end
      FN_MID: begin
        s_t = wal + wah;
        s_lo = s_t >>> 1;
        s_hi = s_t >>> 1;
      end
      FN_ADD: begin
        s_lo = wal + wbl;
        s_hi = wah + wbh;
      end
      FN_SUB: begin
        s_lo = wal - wbh;
        s_hi = wah - wbl;
      end
      FN_MUL: start_path = ST_MUL;
      FN_DIV: begin
        if ((wbl <= 0 && wbh >= 0) || (wbh <= 0 && wbl >= 0)) s_null = 1'b1;
        else start_path = ST_DIV_INIT;
      end
      FN_CONTAINS: s_truth = (wpt >= wal) && (wpt <= wah);
      FN_OVERLAPS: s_truth = (wal <= wbh) && (wbl <= wah);
      FN_INTERSECT: begin
        s_lo = mx(wal, wbl);
        s_hi = mn(wah, wbh);
        if (s_lo > s_hi) s_null = 1'b1;
      end
      FN_HULL: begin
        s_lo = mn(wal, wbl);
        s_hi = mx(wah, wbh);
      end
      FN_POW: begin
        if (exponent[EXP_W-1]) s_null = 1'b1;
        else if (exponent == EXP_W'(0)) begin
          s_lo = ONE_W;
          s_hi = ONE_W;
        end else if (exponent == EXP_W'(1)) begin
          s_lo = wal;
          s_hi = wah;
        end else start_path = ST_POW_INIT;
      end
      FN_SQRT: begin
        if (a_low[WORD_W-1] || a_high[WORD_W-1]) s_null = 1'b1;
        else start_path = ST_SQ_INIT;
      end
      default: begin
        if (wal >= 0) begin
          s_lo = wal;
          s_hi = wah;
        end else if (wah <= 0) begin
          s_lo = -wah;
          s_hi = -wal;
        end else begin
          s_lo = '0;
          s_hi = mx(-wal, wah);
        end
      end
    endcase
    if (s_null) begin
      s_lo = '0;
      s_hi = '0;
      s_truth = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start) state_next = start_path;
      ST_MUL:      if (cnt == CNT_W'(4)) state_next = ST_FINISH;
      ST_DIV_INIT: state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (cnt == CNT_W'(DVD_W-1)) state_next = ST_DIV_FIX;
      ST_DIV_FIX:  state_next = (idx == 2'd3) ? ST_FINISH : ST_DIV_INIT;
      ST_SQ_INIT:  state_next = ST_SQ_STEP;
      ST_SQ_STEP:  if (cnt == CNT_W'(SQ_STEPS-1)) state_next = ST_SQ_FIX;
      ST_SQ_FIX:   state_next = (idx == 2'd1) ? ST_FINISH : ST_SQ_INIT;
      ST_POW_INIT: state_next = ST_POW_MUL;
      ST_POW_MUL:  state_next = ST_POW_ACC;
      ST_POW_ACC:  state_next = (cnt == n_r - CNT_W'(1)) ? ST_POW_FIX : ST_POW_MUL;
      ST_POW_FIX:  state_next = (idx == 2'd3) ? ST_FINISH : ST_POW_INIT;
      ST_FINISH:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs and shared multiplier operands
  always_comb begin
    busy = (state != ST_IDLE);
    if (state == ST_MUL) begin
      mul_a = MUL_W'(cnt[1] ? ah : al);
      mul_b = MUL_W'(cnt[0] ? bh : bl);
    end else begin
      mul_a = signed'({1'b0, pw_r});
      mul_b = signed'({2'b0, pw_m});
    end
    mul_full = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= (state == ST_FINISH);
  end

  // datapath
  logic signed [WIDE_W-1:0] pf, pc, q_w, fl, ce, pw_val, lo_c, hi_c;
  logic [DVD_W:0]           d_t;
  logic                     d_ge;
  logic [SQ_W-1:0]          sq_sum;
  logic [PROD_W-1:0]        pw_p;
  logic [PROD_W-FRAC_W-1:0] pw_s;
  logic [PW_W-1:0]          nsel_unused_guard;

  always_comb begin
    pf = WIDE_W'(prod >>> FRAC_W);
    pc = WIDE_W'((prod + signed'(RND)) >>> FRAC_W);
    d_t = (DVD_W+1)'({rem, dvd[DVD_W-1]});
    d_ge = (d_t >= (DVD_W+1)'(dsr));
    q_w = WIDE_W'(dvd);
    if (dv_neg) begin
      fl = -q_w - WIDE_W'(rem != '0);
      ce = -q_w;
    end else begin
      fl = q_w;
      ce = q_w + WIDE_W'(rem != '0);
    end
    sq_sum = sq_r + sq_bit;
    pw_p = unsigned'(prod) + (pw_up ? RND : '0);
    pw_s = pw_p[PROD_W-1:FRAC_W];
    nsel_unused_guard = PW_CAP;
    pw_val = pw_neg ? -WIDE_W'(pw_r) : WIDE_W'(pw_r);
    lo_c = (acc_lo > WMAX) ? WMAX : ((acc_lo < WMIN) ? WMIN : acc_lo);
    hi_c = (acc_hi > WMAX) ? WMAX : ((acc_hi < WMIN) ? WMIN : acc_hi);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          al <= a_low;
          ah <= a_high;
          bl <= b_low;
          bh <= b_high;
          n_r <= exponent[CNT_W-1:0];
          even_straddle <= !exponent[0] && a_low[WORD_W-1] && (a_high > 0);
          acc_lo <= s_lo;
          acc_hi <= s_hi;
          truth_r <= s_truth;
          null_r <= s_null;
          idx <= '0;
          cnt <= '0;
        end
      end
      ST_MUL: begin
        prod <= PROD_W'(mul_full);
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          acc_lo <= pf;
          acc_hi <= pc;
        end else if (cnt != '0) begin
          acc_lo <= mn(acc_lo, pf);
          acc_hi <= mx(acc_hi, pc);
        end
      end
      ST_DIV_INIT: begin
        dv_neg <= (idx[1] ? ah[WORD_W-1] : al[WORD_W-1]) ^
                  (idx[0] ? bh[WORD_W-1] : bl[WORD_W-1]);
        dvd <= {mag(idx[1] ? ah : al), {FRAC_W{1'b0}}};
        dsr <= mag(idx[0] ? bh : bl);
        rem <= '0;
        cnt <= '0;
      end
      ST_DIV_STEP: begin
        rem <= d_ge ? WORD_W'(d_t - (DVD_W+1)'(dsr)) : WORD_W'(d_t);
        dvd <= {dvd[DVD_W-2:0], d_ge};
        cnt <= cnt + CNT_W'(1);
      end
      ST_DIV_FIX: begin
        if (idx == 2'd0) begin
          acc_lo <= fl;
          acc_hi <= ce;
        end else begin
          acc_lo <= mn(acc_lo, fl);
          acc_hi <= mx(acc_hi, ce);
        end
        idx <= idx + 2'd1;
      end
      ST_SQ_INIT: begin
        sq_x <= {idx[0] ? ah : al, {FRAC_W{1'b0}}};
        sq_r <= '0;
        sq_bit <= SQ_W'(1) << (SQ_W-2);
        cnt <= '0;
      end
      ST_SQ_STEP: begin
        if (sq_x >= sq_sum) begin
          sq_x <= sq_x - sq_sum;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt <= cnt + CNT_W'(1);
      end
      ST_SQ_FIX: begin
        // leftover remainder means the root was inexact: round the upper bound up
        if (idx == 2'd0) acc_lo <= WIDE_W'(sq_r);
        else acc_hi <= WIDE_W'(sq_r) + WIDE_W'(sq_x != '0);
        idx <= idx + 2'd1;
      end
      ST_POW_INIT: begin
        pw_m <= mag(idx[0] ? ah : al);
        pw_neg <= (idx[0] ? ah[WORD_W-1] : al[WORD_W-1]) & n_r[0];
        pw_up <= idx[1] ^ ((idx[0] ? ah[WORD_W-1] : al[WORD_W-1]) & n_r[0]);
        pw_r <= PW_ONE;
        cnt <= '0;
      end
      ST_POW_MUL: prod <= PROD_W'(mul_full);
      ST_POW_ACC: begin
        pw_r <= (pw_s > (PROD_W-FRAC_W)'(nsel_unused_guard)) ? PW_CAP : PW_W'(pw_s);
        cnt <= cnt + CNT_W'(1);
      end
      ST_POW_FIX: begin
        case (idx)
          2'd0: acc_lo <= pw_val;
          2'd1: acc_lo <= mn(acc_lo, pw_val);
          2'd2: acc_hi <= pw_val;
          default: begin
            acc_hi <= mx(acc_hi, pw_val);
            if (even_straddle) acc_lo <= '0;
          end
        endcase
        idx <= idx + 2'd1;
      end
      ST_FINISH: begin
        res_low <= WORD_W'(lo_c);
        res_high <= WORD_W'(hi_c);
        truth <= truth_r && !null_r;
        is_null <= null_r;
        saturated <= !null_r && ((lo_c != acc_lo) || (hi_c != acc_hi));
      end
      default: ;
    endcase
  end

  `IAU_ASSERT_IMPL(chk_done_after_busy, done, $past(busy) && !busy, "done without a transaction")
  `IAU_ASSERT_IMPL(chk_null_clean, done && is_null, res_low == 0 && res_high == 0 && !truth && !saturated, "null result not cleared")
  `IAU_ASSERT_NEXT(chk_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `IAU_ASSERT_NEXT(chk_done_pulse, done, !done, "done strobe longer than one cycle")

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for interval_arithmetic_unit_core: directed and random ops,
// predicted in a scoreboard class. Depends on rtl/iau_pkg.sv and the core RTL.
module tb_top;
  import iau_pkg::*;

  localparam longint ONE_Q = 64'sd1 <<< FRAC_W;
  localparam longint WMAX  = 64'sd2147483647;
  localparam longint WMIN  = -64'sd2147483648;

  typedef struct {
    logic [WORD_W-1:0] lo, hi;
    logic truth, nul, sat;
  } iv_result_t;

  class iv_scoreboard;
    iv_result_t pending[$];
    int errors;
    bit sat;

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    function longint clampw(longint v);
      if (v > WMAX) begin sat = 1; return WMAX; end
      if (v < WMIN) begin sat = 1; return WMIN; end
      return v;
    endfunction

    function longint fshift(longint v);
      return v >>> FRAC_W;
    endfunction

    function longint fdiv(longint n, longint d);
      longint q, r;
      q = n / d; r = n % d;
      if (r != 0 && ((r < 0) != (d < 0))) q--;
      return q;
    endfunction

    function longint cdiv(longint n, longint d);
      longint q, r;
      q = n / d; r = n % d;
      if (r != 0 && ((r < 0) == (d < 0))) q++;
      return q;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin x -= r + b; r = (r >> 1) + b; end
        else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    // magnitude power with per-step rounding, capped just past the word range
    function longint spow(longint x, int n, bit upper);
      bit neg, up;
      longint unsigned m, r, p;
      neg = (x < 0) && n[0];
      up = upper != neg;
      m = (x < 0) ? -x : x;
      r = ONE_Q;
      for (int i = 0; i < n; i++) begin
        p = r * m;
        if (up) p += ONE_Q - 1;
        r = p >> FRAC_W;
        if (r > 64'h80000001) r = 64'h80000001;
      end
      return neg ? -longint'(r) : longint'(r);
    endfunction

    function longint mn(longint a, longint b); return a < b ? a : b; endfunction
    function longint mx(longint a, longint b); return a > b ? a : b; endfunction

    function void note(func_t f, longint al, longint ah, longint bl, longint bh,
                       longint pt, int n);
      iv_result_t e;
      longint lo, hi, p0, p1, p2, p3;
      longint unsigned v, s;
      bit t, nul;
      lo = 0; hi = 0; t = 0; nul = 0; sat = 0;
      case (f)
        FN_MAKE: begin lo = mn(al, ah); hi = mx(al, ah); end
        FN_LO: begin lo = al; hi = al; end
        FN_HI: begin lo = ah; hi = ah; end
        FN_WIDTH: begin lo = clampw(ah - al); hi = lo; end
        FN_MID: begin lo = fdiv(al + ah, 2); hi = lo; end
        FN_ADD: begin lo = clampw(al + bl); hi = clampw(ah + bh); end
        FN_SUB: begin lo = clampw(al - bh); hi = clampw(ah - bl); end
        FN_MUL: begin
          p0 = al * bl; p1 = al * bh; p2 = ah * bl; p3 = ah * bh;
          lo = mn(mn(p0, p1), mn(p2, p3)); hi = mx(mx(p0, p1), mx(p2, p3));
          lo = clampw(fshift(lo)); hi = clampw(fshift(hi + ONE_Q - 1));
        end
        FN_DIV: begin
          if (mn(bl, bh) <= 0 && mx(bl, bh) >= 0) nul = 1;
          else begin
            lo = mn(mn(fdiv(al * ONE_Q, bl), fdiv(al * ONE_Q, bh)),
                    mn(fdiv(ah * ONE_Q, bl), fdiv(ah * ONE_Q, bh)));
            hi = mx(mx(cdiv(al * ONE_Q, bl), cdiv(al * ONE_Q, bh)),
                    mx(cdiv(ah * ONE_Q, bl), cdiv(ah * ONE_Q, bh)));
            lo = clampw(lo); hi = clampw(hi);
          end
        end
        FN_CONTAINS: t = (pt >= al && pt <= ah);
        FN_OVERLAPS: t = (al <= bh && bl <= ah);
        FN_INTERSECT: begin
          lo = mx(al, bl); hi = mn(ah, bh);
          if (lo > hi) nul = 1;
        end
        FN_HULL: begin lo = mn(al, bl); hi = mx(ah, bh); end
        FN_POW: begin
          if (n < 0) nul = 1;
          else if (n == 0) begin lo = ONE_Q; hi = ONE_Q; end
          else if (n == 1) begin lo = al; hi = ah; end
          else if (!n[0] && al < 0 && ah > 0) begin
            lo = 0; hi = clampw(mx(spow(al, n, 1), spow(ah, n, 1)));
          end else begin
            lo = clampw(mn(spow(al, n, 0), spow(ah, n, 0)));
            hi = clampw(mx(spow(al, n, 1), spow(ah, n, 1)));
          end
        end
        FN_SQRT: begin
          if (al < 0 || ah < 0) nul = 1;
          else begin
            lo = isqrt(longint'(al) << FRAC_W);
            v = longint'(ah) << FRAC_W;
            s = isqrt(v);
            if (s * s < v) s++;
            hi = s;
            lo = clampw(lo); hi = clampw(hi);
          end
        end
        default: begin
          if (al >= 0) begin lo = al; hi = ah; end
          else if (ah <= 0) begin lo = clampw(-ah); hi = clampw(-al); end
          else begin lo = 0; hi = clampw(mx(-al, ah)); end
        end
      endcase
      if (nul) begin lo = 0; hi = 0; t = 0; sat = 0; end
      e.lo = lo[WORD_W-1:0]; e.hi = hi[WORD_W-1:0];
      e.truth = t; e.nul = nul; e.sat = sat;
      pending.push_back(e);
    endfunction

    task check(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi,
               logic t, logic nul, logic st);
      iv_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", lo, 0);
        return;
      end
      e = pending.pop_front();
      if (lo !== e.lo) report("res_low", lo, e.lo);
      if (hi !== e.hi) report("res_high", hi, e.hi);
      if (t !== e.truth) report("truth", t, e.truth);
      if (nul !== e.nul) report("is_null", nul, e.nul);
      if (st !== e.sat) report("saturated", st, e.sat);
    endtask
  endclass

  logic clk, rst, start, busy, done;
  logic [FUNC_W-1:0] func;
  logic signed [WORD_W-1:0] a_low, a_high, b_low, b_high, point_value;
  logic signed [EXP_W-1:0] exponent;
  logic signed [WORD_W-1:0] res_low, res_high;
  logic truth, is_null, saturated;
  iv_scoreboard sb;
  int idle_pct;

  interval_arithmetic_unit_core uut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note(func_t'(func), a_low, a_high, b_low, b_high, point_value, exponent);
      if (done) sb.check(res_low, res_high, truth, is_null, saturated);
    end
  end

  task automatic send(func_t f, logic [WORD_W-1:0] al, logic [WORD_W-1:0] ah,
                      logic [WORD_W-1:0] bl, logic [WORD_W-1:0] bh,
                      logic [WORD_W-1:0] pt, logic [EXP_W-1:0] n);
    @(negedge clk);
    func <= f; a_low <= al; a_high <= ah; b_low <= bl; b_high <= bh;
    point_value <= pt; exponent <= n; start <= 1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(2) == 0 ? 32'h0 : ($urandom_range(1) ? 32'h10000 : 32'hffff0000);
      2, 3: return $signed($urandom_range(1 << 19)) - (1 << 18);
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_item();
    func_t f;
    logic [WORD_W-1:0] al, ah, bl, bh, t;
    logic [EXP_W-1:0] n;
    f = func_t'($urandom_range(15));
    al = pick(); ah = pick(); bl = pick(); bh = pick();
    // mostly well-ordered intervals, some reversed
    if ($urandom_range(9) != 0 && $signed(al) > $signed(ah)) begin t = al; al = ah; ah = t; end
    if ($urandom_range(9) != 0 && $signed(bl) > $signed(bh)) begin t = bl; bl = bh; bh = t; end
    if (f == FN_SQRT && $urandom_range(3) != 0) begin al[31] = 0; ah[31] = 0; end
    if (f == FN_DIV && $urandom_range(3) != 0) begin
      bl = $urandom_range(1, 32'h7fffff);
      bh = bl + $urandom_range(32'hffff);
      if ($urandom_range(1)) begin t = -bl; bl = -bh; bh = t; end
    end
    if (f == FN_POW && $urandom_range(4) != 0) begin
      al = $signed($urandom_range(1 << 18)) - (1 << 17);
      ah = al + $urandom_range(1 << 17);
    end
    n = $urandom_range(4) == 0 ? EXP_W'($urandom) : EXP_W'($urandom_range(8));
    send(f, al, ah, bl, bh, pick(), n);
  endtask

  initial begin
    sb = new();
    rst = 1; start = 0; func = FN_MAKE; a_low = 0; a_high = 0; b_low = 0;
    b_high = 0; point_value = 0; exponent = 0; idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: every op, extremes and the null / saturation corners
    send(FN_MAKE, 32'h00030000, 32'hfffe0000, 0, 0, 0, 0);
    send(FN_LO, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    send(FN_HI, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    send(FN_WIDTH, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0);
    send(FN_MID, 32'hffffffff, 32'h0, 0, 0, 0, 0);
    send(FN_ADD, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1, 0, 0);
    send(FN_SUB, 32'h80000000, 32'h0, 32'h1, 32'h1, 0, 0);
    send(FN_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
    send(FN_MUL, 32'hfffe8000, 32'h00018000, 32'h00000001, 32'h00000003, 0, 0);
    send(FN_DIV, 32'h00010000, 32'h00020000, 32'hffff0000, 32'h00010000, 0, 0);
    send(FN_DIV, 32'h80000000, 32'h7fffffff, 32'h00000001, 32'h00000003, 0, 0);
    send(FN_DIV, 32'h00010000, 32'h00030000, 32'hfffd0000, 32'hffff0000, 0, 0);
    send(FN_CONTAINS, 32'hffff0000, 32'h00010000, 0, 0, 32'h00010000, 0);
    send(FN_CONTAINS, 32'hffff0000, 32'h00010000, 0, 0, 32'h00010001, 0);
    send(FN_OVERLAPS, 0, 32'h10000, 32'h10000, 32'h20000, 0, 0);
    send(FN_INTERSECT, 0, 32'h10000, 32'h10001, 32'h20000, 0, 0);
    send(FN_HULL, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0);
    send(FN_POW, 32'hfffe0000, 32'h00030000, 0, 0, 0, 7'sd2);
    send(FN_POW, 32'h80000000, 32'h7fffffff, 0, 0, 0, 7'sd63);
    send(FN_POW, 32'hfffe0000, 32'hffff0000, 0, 0, 0, 7'sd3);
    send(FN_POW, 32'h00010000, 32'h00020000, 0, 0, 0, 7'h40);
    send(FN_POW, 32'h00010000, 32'h00020000, 0, 0, 0, 7'sd0);
    send(FN_SQRT, 32'h0, 32'h7fffffff, 0, 0, 0, 0);
    send(FN_SQRT, 32'hffffffff, 32'h00010000, 0, 0, 0, 0);
    send(FN_ABS, 32'h80000000, 32'h00010000, 0, 0, 0, 0);
    send(FN_ABS, 32'h80000000, 32'hffff0000, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3) ? 16 : 59;
      repeat (350) rand_item();
      drain();
    end

    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/iau_pkg.sv
rtl/interval_arithmetic_unit_core.sv
tb/tb_top.sv
